// ===== hw/rtl/bmp_pkg.sv =====
package bmp_pkg;

   localparam int COORD_BITS_DEF = 12;

   localparam logic [5:0] HEADER_LAST = 6'd53;
   localparam logic [5:0] WIDTH_OFS   = 6'd18;
   localparam logic [5:0] WIDTH_LAST  = 6'd21;
   localparam logic [5:0] HEIGHT_OFS  = 6'd22;
   localparam logic [5:0] HEIGHT_LAST = 6'd25;
   localparam logic [5:0] BPP_LO_OFS  = 6'd28;
   localparam logic [5:0] BPP_HI_OFS  = 6'd29;

   localparam logic [15:0] BPP_RGB24 = 16'd24;

   localparam logic [1:0] BYTE_BLUE  = 2'd0;
   localparam logic [1:0] BYTE_GREEN = 2'd1;
   localparam logic [1:0] BYTE_RED   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_PIXEL     = 2'd0,
      STATUS_BAD_DEPTH = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_PIXELS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef struct packed {
      status_type status;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } rsp_head_type;

endpackage

// ===== hw/rtl/bmp_channel_if.sv =====
interface bmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface bmp_rsp_if #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   bmp_pkg::status_type    status;
   logic [7:0]             red;
   logic [7:0]             green;
   logic [7:0]             blue;
   logic [COORD_BITS-1:0]  row;
   logic [COORD_BITS-1:0]  column;
   logic                   last_pixel;

   modport source (output valid, output status, output red, output green, output blue,
                   output row, output column, output last_pixel, input ready);
   modport sink (input valid, input status, input red, input green, input blue,
                 input row, input column, input last_pixel, output ready);
endinterface

// ===== hw/rtl/bmp_rgb24_stream_parser.sv =====
// Throughput: one input word per cycle, limited by nothing but output backpressure.
// Every word passes an input register, one step of the header and pixel counters,
// and the result register; words that produce no result only advance the counters.
// Reset is synchronous and clears all control state; parsing then starts at
// header byte 0, as it does after any word flagged as the start of a file.
module bmp_rgb24_stream_parser #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bmp_req_if.sink   req_bus,
   bmp_rsp_if.source rsp_bus
);
   import bmp_pkg::*;

   logic                  in_valid;
   logic [7:0]            in_byte;
   logic                  in_start;
   logic                  can_take;
   logic                  step;
   logic                  hit;
   rsp_head_type          head;
   logic [COORD_BITS-1:0] row;
   logic [COORD_BITS-1:0] column;

   assign step = in_valid && can_take;

   bmp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .take       (step),
      .req_bus    (req_bus),
      .valid      (in_valid),
      .data_byte  (in_byte),
      .file_start (in_start)
   );

   bmp_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte),
      .file_start (in_start),
      .hit        (hit),
      .head       (head),
      .row        (row),
      .column     (column)
   );

   bmp_out_reg #(
      .COORD_BITS (COORD_BITS)
   ) u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && hit),
      .head     (head),
      .row      (row),
      .column   (column),
      .can_take (can_take),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== hw/rtl/bmp_in_reg.sv =====
module bmp_in_reg (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   bmp_req_if.sink     req_bus,
   output logic        valid,
   output logic [7:0]  data_byte,
   output logic        file_start
);
   import bmp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       load;

   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= req_bus.data_byte;
         start_ff <= req_bus.file_start;
      end
   end

   assign valid      = valid_ff;
   assign data_byte  = byte_ff;
   assign file_start = start_ff;

endmodule

// ===== hw/rtl/bmp_core.sv =====
module bmp_core #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   file_start,
   output logic                   hit,
   output bmp_pkg::rsp_head_type  head,
   output logic [COORD_BITS-1:0]  row,
   output logic [COORD_BITS-1:0]  column
);
   import bmp_pkg::*;

   localparam logic [31:0] COORD_MASK = 32'((64'd1 << COORD_BITS) - 64'd1);

   phase_type             phase_ff, phase_in, cur_phase;
   logic [5:0]            pos_ff, pos_in, cur_pos;
   logic [COORD_BITS-1:0] width_ff, width_in, cur_width;
   logic [COORD_BITS-1:0] height_ff, height_in, cur_height;
   logic [15:0]           bpp_ff, bpp_in, cur_bpp;
   logic                  ovf_ff, ovf_in, cur_ovf;
   logic [1:0]            bip_ff, bip_in, cur_bip;
   logic [7:0]            blue_ff, blue_in;
   logic [7:0]            green_ff, green_in;
   logic [COORD_BITS-1:0] col_ff, col_in, cur_col;
   logic [COORD_BITS-1:0] row_ff, row_in, cur_row;
   logic [1:0]            pad_ff, pad_in, cur_pad;

   logic                  in_width, in_height;
   logic [5:0]            field_ofs;
   logic [31:0]           shifted;
   logic                  shift_over;
   logic [COORD_BITS:0]   col_plus, row_plus;
   logic                  last_col, last_all;

   // A new file restarts from the reset state before the byte is used.
   always_comb begin
      if (file_start) begin
         cur_phase  = PH_HEADER;
         cur_pos    = '0;
         cur_width  = '0;
         cur_height = '0;
         cur_bpp    = '0;
         cur_ovf    = 1'b0;
         cur_bip    = '0;
         cur_col    = '0;
         cur_row    = '0;
         cur_pad    = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = pos_ff;
         cur_width  = width_ff;
         cur_height = height_ff;
         cur_bpp    = bpp_ff;
         cur_ovf    = ovf_ff;
         cur_bip    = bip_ff;
         cur_col    = col_ff;
         cur_row    = row_ff;
         cur_pad    = pad_ff;
      end
   end

   assign in_width   = cur_pos inside {[WIDTH_OFS:WIDTH_LAST]};
   assign in_height  = cur_pos inside {[HEIGHT_OFS:HEIGHT_LAST]};
   assign field_ofs  = in_width ? (cur_pos - WIDTH_OFS) : (cur_pos - HEIGHT_OFS);
   assign shifted    = 32'(data_byte) << {field_ofs[1:0], 3'b000};
   assign shift_over = |(shifted & ~COORD_MASK);

   assign col_plus = {1'b0, cur_col} + 1'b1;
   assign row_plus = {1'b0, cur_row} + 1'b1;
   assign last_col = col_plus >= {1'b0, cur_width};
   assign last_all = last_col && (row_plus >= {1'b0, cur_height});

   always_comb begin
      phase_in  = cur_phase;
      pos_in    = cur_pos;
      width_in  = cur_width;
      height_in = cur_height;
      bpp_in    = cur_bpp;
      ovf_in    = cur_ovf;
      bip_in    = cur_bip;
      blue_in   = blue_ff;
      green_in  = green_ff;
      col_in    = cur_col;
      row_in    = cur_row;
      pad_in    = cur_pad;
      hit       = 1'b0;
      head      = '0;
      row       = '0;
      column    = '0;

      case (cur_phase)
         PH_HEADER: begin
            if (in_width) begin
               width_in = cur_width | shifted[COORD_BITS-1:0];
               ovf_in   = cur_ovf | shift_over;
            end else if (in_height) begin
               height_in = cur_height | shifted[COORD_BITS-1:0];
               ovf_in    = cur_ovf | shift_over;
            end else if (cur_pos == BPP_LO_OFS) begin
               bpp_in = {cur_bpp[15:8], data_byte};
            end else if (cur_pos == BPP_HI_OFS) begin
               bpp_in = {data_byte, cur_bpp[7:0]};
            end

            if (cur_pos != HEADER_LAST) begin
               pos_in = cur_pos + 1'b1;
            end else if (bpp_in != BPP_RGB24) begin
               phase_in    = PH_DONE;
               hit         = 1'b1;
               head.status = STATUS_BAD_DEPTH;
            end else if (ovf_in) begin
               phase_in    = PH_DONE;
               hit         = 1'b1;
               head.status = STATUS_TOO_LARGE;
            end else begin
               phase_in = (width_in == '0 || height_in == '0) ? PH_DONE : PH_PIXELS;
               bip_in   = '0;
               col_in   = '0;
               row_in   = '0;
               pad_in   = '0;
            end
         end
         PH_PIXELS: begin
            if (cur_pad != '0) begin
               pad_in = cur_pad - 1'b1;
            end else if (cur_bip == BYTE_BLUE) begin
               blue_in = data_byte;
               bip_in  = BYTE_GREEN;
            end else if (cur_bip == BYTE_GREEN) begin
               green_in = data_byte;
               bip_in   = BYTE_RED;
            end else begin
               hit             = 1'b1;
               head.status     = STATUS_PIXEL;
               head.red        = data_byte;
               head.green      = green_ff;
               head.blue       = blue_ff;
               head.last_pixel = last_all;
               row             = cur_row;
               column          = cur_col;
               bip_in          = BYTE_BLUE;
               if (last_all) begin
                  phase_in = PH_DONE;
               end else if (last_col) begin
                  col_in = '0;
                  row_in = row_plus[COORD_BITS-1:0];
                  pad_in = cur_width[1:0];
               end else begin
                  col_in = col_plus[COORD_BITS-1:0];
               end
            end
         end
         default: begin
            phase_in = cur_phase;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         bpp_ff    <= '0;
         ovf_ff    <= 1'b0;
         bip_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         ovf_ff    <= ovf_in;
         bip_ff    <= bip_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

endmodule

// ===== hw/rtl/bmp_out_reg.sv =====
module bmp_out_reg #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bmp_pkg::rsp_head_type  head,
   input  logic [COORD_BITS-1:0]  row,
   input  logic [COORD_BITS-1:0]  column,
   output logic                   can_take,
   bmp_rsp_if.source              rsp_bus
);
   import bmp_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   rsp_head_type          head_ff;
   logic [COORD_BITS-1:0] row_ff;
   logic [COORD_BITS-1:0] col_ff;

   assign can_take = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         head_ff <= head;
         row_ff  <= row;
         col_ff  <= column;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.status     = head_ff.status;
   assign rsp_bus.red        = head_ff.red;
   assign rsp_bus.green      = head_ff.green;
   assign rsp_bus.blue       = head_ff.blue;
   assign rsp_bus.row        = row_ff;
   assign rsp_bus.column     = col_ff;
   assign rsp_bus.last_pixel = head_ff.last_pixel;

endmodule

// ===== hw/rtl/bmp_checks.sv =====
module bmp_checks #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_status,
   input logic [7:0]            rsp_red,
   input logic [7:0]            rsp_green,
   input logic [7:0]            rsp_blue,
   input logic [COORD_BITS-1:0] rsp_row,
   input logic [COORD_BITS-1:0] rsp_column,
   input logic                  rsp_last_pixel
);
   import bmp_pkg::*;

   logic req_seen;

   assign req_seen = req_valid;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_status, rsp_red, rsp_green, rsp_blue,
                                           rsp_row, rsp_column, rsp_last_pixel}))
      else $error("result word changed while stalled");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_PIXEL |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 &&
         rsp_row == '0 && rsp_column == '0 && !rsp_last_pixel)
      else $error("error word carries pixel data");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && (req_seen || !req_seen) |-> req_ready)
      else $error("input not ready while the result side is empty");

endmodule

bind bmp_rgb24_stream_parser bmp_checks #(
   .COORD_BITS (COORD_BITS)
) u_bmp_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_red        (rsp_bus.red),
   .rsp_green      (rsp_bus.green),
   .rsp_blue       (rsp_bus.blue),
   .rsp_row        (rsp_bus.row),
   .rsp_column     (rsp_bus.column),
   .rsp_last_pixel (rsp_bus.last_pixel)
);

// ===== dv/bmp_pixel_checker.sv =====
`timescale 1ns / 1ps

module bmp_pixel_checker #(
   parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_file_start,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bmp_pkg::status_type    rsp_status,
   input  logic [7:0]             rsp_red,
   input  logic [7:0]             rsp_green,
   input  logic [7:0]             rsp_blue,
   input  logic [COORD_BITS-1:0]  rsp_row,
   input  logic [COORD_BITS-1:0]  rsp_column,
   input  logic                   rsp_last_pixel,
   output int                     mismatch_count,
   output int                     expected_count
);
   import bmp_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      status_type            status;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] column;
      logic                  last_pixel;
   } pixel_word_type;

   pixel_word_type expected_pixels[$];

   phase_type             parse_phase;
   logic [5:0]            hdr_pos;
   logic [COORD_BITS-1:0] img_width;
   logic [COORD_BITS-1:0] img_height;
   logic [15:0]           depth;
   logic                  too_large;
   logic [1:0]            byte_idx;
   logic [7:0]            held_blue;
   logic [7:0]            held_green;
   logic [COORD_BITS-1:0] col_count;
   logic [COORD_BITS-1:0] row_count;
   logic [1:0]            pad_left;
   int                    words_checked;

   initial begin
      mismatch_count = 0;
      expected_count = 0;
      words_checked = 0;
   end

   task automatic clear_parse();
      parse_phase = PH_HEADER;
      hdr_pos = '0;
      img_width = '0;
      img_height = '0;
      depth = '0;
      too_large = 1'b0;
      byte_idx = BYTE_BLUE;
      held_blue = '0;
      held_green = '0;
      col_count = '0;
      row_count = '0;
      pad_left = '0;
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("MISMATCH at %0t, result word %0d: %s", $time, words_checked, msg);
      end
      mismatch_count++;
   endtask

   // Width and height are little-endian 32-bit fields; any bit that lands at or
   // above the coordinate range marks the image as too large.
   task automatic predict_byte(input logic [7:0] data, input logic start);
      logic [31:0]    shifted;
      logic           last_col;
      logic           last_row;
      pixel_word_type word;
      if (start) begin
         clear_parse();
      end
      word = '0;
      case (parse_phase)
         PH_HEADER: begin
            if (hdr_pos >= WIDTH_OFS && hdr_pos <= WIDTH_LAST) begin
               shifted = 32'(data) << (8 * (hdr_pos - WIDTH_OFS));
               img_width = img_width | shifted[COORD_BITS-1:0];
               if ((shifted >> COORD_BITS) != 0) too_large = 1'b1;
            end else if (hdr_pos >= HEIGHT_OFS && hdr_pos <= HEIGHT_LAST) begin
               shifted = 32'(data) << (8 * (hdr_pos - HEIGHT_OFS));
               img_height = img_height | shifted[COORD_BITS-1:0];
               if ((shifted >> COORD_BITS) != 0) too_large = 1'b1;
            end else if (hdr_pos == BPP_LO_OFS) begin
               depth[7:0] = data;
            end else if (hdr_pos == BPP_HI_OFS) begin
               depth[15:8] = data;
            end
            if (hdr_pos != HEADER_LAST) begin
               hdr_pos++;
            end else if (depth != BPP_RGB24) begin
               word.status = STATUS_BAD_DEPTH;
               parse_phase = PH_DONE;
               expected_pixels.push_back(word);
            end else if (too_large) begin
               word.status = STATUS_TOO_LARGE;
               parse_phase = PH_DONE;
               expected_pixels.push_back(word);
            end else begin
               if (img_width == 0 || img_height == 0) begin
                  parse_phase = PH_DONE;
               end else begin
                  parse_phase = PH_PIXELS;
               end
               byte_idx = BYTE_BLUE;
               col_count = '0;
               row_count = '0;
               pad_left = '0;
            end
         end
         PH_PIXELS: begin
            if (pad_left != 0) begin
               pad_left--;
            end else if (byte_idx == BYTE_BLUE) begin
               held_blue = data;
               byte_idx = BYTE_GREEN;
            end else if (byte_idx == BYTE_GREEN) begin
               held_green = data;
               byte_idx = BYTE_RED;
            end else begin
               last_col = (int'(col_count) + 1 >= int'(img_width));
               last_row = (int'(row_count) + 1 >= int'(img_height));
               word.status = STATUS_PIXEL;
               word.red = data;
               word.green = held_green;
               word.blue = held_blue;
               word.row = row_count;
               word.column = col_count;
               word.last_pixel = last_col && last_row;
               expected_pixels.push_back(word);
               byte_idx = BYTE_BLUE;
               if (word.last_pixel) begin
                  parse_phase = PH_DONE;
               end else if (last_col) begin
                  col_count = '0;
                  row_count++;
                  pad_left = img_width[1:0];
               end else begin
                  col_count++;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_word();
      pixel_word_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected word, status %0d row %0d column %0d",
                                   rsp_status, rsp_row, rsp_column));
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
         if (rsp_red !== want.red)
            report_mismatch($sformatf("red %0h, expected %0h", rsp_red, want.red));
         if (rsp_green !== want.green)
            report_mismatch($sformatf("green %0h, expected %0h", rsp_green, want.green));
         if (rsp_blue !== want.blue)
            report_mismatch($sformatf("blue %0h, expected %0h", rsp_blue, want.blue));
         if (rsp_row !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", rsp_row, want.row));
         if (rsp_column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d", rsp_column, want.column));
         if (rsp_last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                      rsp_last_pixel, want.last_pixel));
      end
      words_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) predict_byte(req_data_byte, req_file_start);
      end
      expected_count <= expected_pixels.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bmp_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int HEADER_BYTES = int'(HEADER_LAST) + 1;
   localparam int TOTAL_ITEMS = 850;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset;
   logic long_hold = 1'b0;
   logic sender_bursting = 1'b0;
   int   mismatch_count;
   int   expected_count;
   int   cycle_count = 0;
   int   words_sent = 0;

   bmp_req_if req_bus ();
   bmp_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   bmp_rgb24_stream_parser #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bmp_pixel_checker #(.COORD_BITS(COORD_BITS)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_data_byte  (req_bus.data_byte),
      .req_file_start (req_bus.file_start),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_red        (rsp_bus.red),
      .rsp_green      (rsp_bus.green),
      .rsp_blue       (rsp_bus.blue),
      .rsp_row        (rsp_bus.row),
      .rsp_column     (rsp_bus.column),
      .rsp_last_pixel (rsp_bus.last_pixel),
      .mismatch_count (mismatch_count),
      .expected_count (expected_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int image_bytes(input int width, input int height);
      return height * (3 * width + width % 4);
   endfunction

   task automatic send_word(input logic [7:0] data, input logic start);
      int idle;
      idle = sender_bursting ? 0 : idle_cycles();
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.file_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   // The header is random apart from the three captured fields; the body is
   // random bytes, which covers pixel data, row padding and trailing bytes.
   task automatic send_file(input logic start, input logic [31:0] width,
                            input logic [31:0] height, input logic [15:0] depth,
                            input int body_len);
      logic [7:0] header [HEADER_BYTES];
      foreach (header[i]) header[i] = 8'($urandom);
      for (int k = 0; k < 4; k++) begin
         header[int'(WIDTH_OFS) + k] = width[8*k +: 8];
         header[int'(HEIGHT_OFS) + k] = height[8*k +: 8];
      end
      header[BPP_LO_OFS] = depth[7:0];
      header[BPP_HI_OFS] = depth[15:8];
      for (int i = 0; i < HEADER_BYTES; i++) send_word(header[i], start && i == 0);
      repeat (body_len) send_word(8'($urandom), 1'b0);
   endtask

   initial begin
      int run;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            repeat (run) @(posedge clock);
            run = idle_cycles();
            if (run > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (run) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int          kind;
      int          files;
      int          cut;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] depth;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.file_start <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The first file has no start flag, since reset already expects a header.
      send_file(1'b0, 2, 2, BPP_RGB24, image_bytes(2, 2) + 4);
      send_file(1'b1, 3, 1, 16'd32, 5);
      send_file(1'b1, 32'd4096, 1, 16'd8, 3);
      send_file(1'b1, 32'd4096, 1, BPP_RGB24, 3);
      send_file(1'b1, 1, 32'hFFFF_FFFF, BPP_RGB24, 2);
      send_file(1'b1, 0, 5, BPP_RGB24, 10);
      send_file(1'b1, 7, 0, BPP_RGB24, 10);
      send_file(1'b1, 3, 2, BPP_RGB24, image_bytes(3, 2));
      send_file(1'b1, 32'd4095, 32'd4095, BPP_RGB24, 30);

      files = 0;
      while (words_sent < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 19);
         sender_bursting = ($urandom_range(0, 3) == 0);
         width = $urandom_range(1, 8);
         height = $urandom_range(1, 4);
         if (files == 0) begin
            sender_bursting = 1'b1;
            long_hold = 1'b1;
            req_bus.valid <= 1'b0;
            wait (!long_hold);
            send_file(1'b1, 8, 4, BPP_RGB24, image_bytes(8, 4));
         end else if (kind == 0) begin
            depth = 16'($urandom);
            if (depth == BPP_RGB24) depth = '0;
            send_file(1'b1, width, height, depth, $urandom_range(0, 6));
         end else if (kind == 1) begin
            if ($urandom_range(0, 1) == 1) begin
               width = $urandom;
               width[$urandom_range(COORD_BITS, 31)] = 1'b1;
            end else begin
               height = $urandom;
               height[$urandom_range(COORD_BITS, 31)] = 1'b1;
            end
            send_file(1'b1, width, height, BPP_RGB24, $urandom_range(0, 6));
         end else if (kind == 2) begin
            cut = $urandom_range(1, image_bytes(width, height) - 1);
            send_file(1'b1, width, height, BPP_RGB24, cut);
         end else if (kind == 3) begin
            cut = $urandom_range(1, HEADER_BYTES - 1);
            for (int i = 0; i < cut; i++) send_word(8'($urandom), i == 0);
         end else begin
            cut = (kind == 4) ? $urandom_range(1, 5) : 0;
            send_file(1'b1, width, height, BPP_RGB24, image_bytes(width, height) + cut);
         end
         files++;
      end
      req_bus.valid <= 1'b0;

      do @(negedge clock); while (expected_count != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
